### rtl/v3n_pkg.sv
package v3n_pkg;

    // Fraction bits of the unit vector components (Q2.30)
    localparam int UNIT_FRAC = 30;
    // Quotient bits of one scaled division, enough to hold 2^UNIT_FRAC itself
    localparam int QUOT_W    = UNIT_FRAC + 1;
    // Width of the unit vector ports
    localparam int UNIT_W    = 32;

endpackage

### rtl/vector3_normalize.sv
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-------------------------------
// command   | vec_x, vec_y, vec_z                    | start high, busy low at edge
// result    | magnitude, unit_x/y/z, zero_length     | done high for one cycle
//
// One word enters each cycle; busy stays low since nothing downstream can stall.
// From the accepting edge to done, a word passes these pipeline stages in order:
// input register, squares, sum, one stage per root bit, one stage per quotient bit
// (UNIT_FRAC + 1), and the output register. The root and quotient stages make up most of it.
// rst_n clears only the valid bits; payload registers are never reset.
module vector3_normalize #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COMP_WIDTH-1:0]   vec_x,
    input  logic signed [COMP_WIDTH-1:0]   vec_y,
    input  logic signed [COMP_WIDTH-1:0]   vec_z,
    output logic                           done,
    output logic        [COMP_WIDTH-1:0]   magnitude,
    output logic signed [v3n_pkg::UNIT_W-1:0] unit_x,
    output logic signed [v3n_pkg::UNIT_W-1:0] unit_y,
    output logic signed [v3n_pkg::UNIT_W-1:0] unit_z,
    output logic                           zero_length
);
    import v3n_pkg::*;

    localparam int W = COMP_WIDTH;
    // Length scales with the inputs, so the fraction point never enters the math
    localparam int INT_BITS = COMP_WIDTH - FRAC_BITS;
    localparam int LAT = W + QUOT_W + 4;

    // ---------------- input stage: magnitudes and signs ----------------
    logic         in_vld_reg;
    logic [W-1:0] in_abs_reg [0:2];
    logic [2:0]   in_neg_reg;
    logic [W-1:0] in_abs_next [0:2];
    logic [W-1:0] in_raw [0:2];

    assign busy = 1'b0;
    assign in_raw[0] = vec_x;
    assign in_raw[1] = vec_y;
    assign in_raw[2] = vec_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_abs_next[i] = in_raw[i][W-1] ? (~in_raw[i] + 1'b1) : in_raw[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_abs_reg[i] <= in_abs_next[i];
            in_neg_reg[i] <= in_raw[i][W-1];
        end
    end

    // ---------------- square stage ----------------
    logic           sq_vld_reg;
    logic [2*W-1:0] sq_reg [0:2];
    logic [W-1:0]   sq_abs_reg [0:2];
    logic [2:0]     sq_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else
            sq_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i]     <= in_abs_reg[i] * in_abs_reg[i];
            sq_abs_reg[i] <= in_abs_reg[i];
        end
        sq_neg_reg <= in_neg_reg;
    end

    // ---------------- sum stage: loads the head of the root chain ----------------
    // The sum of three squares stays below 2^(2W), so 2W bits hold it
    logic           rt_vld_reg  [0:W];
    logic [2*W-1:0] rt_n_reg    [0:W];
    logic [W+1:0]   rt_rem_reg  [0:W];
    logic [W-1:0]   rt_root_reg [0:W];
    logic [W-1:0]   rt_abs_reg  [0:W][0:2];
    logic [2:0]     rt_neg_reg  [0:W];
    logic [2*W+1:0] sum_next;

    assign sum_next = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_vld_reg[0] <= 1'b0;
        else
            rt_vld_reg[0] <= sq_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        rt_n_reg[0]    <= sum_next[2*W-1:0];
        rt_rem_reg[0]  <= '0;
        rt_root_reg[0] <= '0;
        rt_abs_reg[0]  <= sq_abs_reg;
        rt_neg_reg[0]  <= sq_neg_reg;
    end

    // ---------------- square root: one root bit per stage ----------------
    for (genvar k = 0; k < W; k++)
    begin : g_root
        logic [W+1:0] rem_sh;
        logic [W+1:0] trial;
        logic         fits;

        assign rem_sh = {rt_rem_reg[k][W-1:0], rt_n_reg[k][2*W-1 -: 2]};
        assign trial  = {rt_root_reg[k], 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_vld_reg[k+1] <= 1'b0;
            else
                rt_vld_reg[k+1] <= rt_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rt_n_reg[k+1]    <= rt_n_reg[k] << 2;
            rt_rem_reg[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
            rt_root_reg[k+1] <= {rt_root_reg[k][W-2:0], fits};
            rt_abs_reg[k+1]  <= rt_abs_reg[k];
            rt_neg_reg[k+1]  <= rt_neg_reg[k];
        end
    end

    // ---------------- scaled division: one quotient bit per stage ----------------
    // Each lane computes floor(abs * 2^UNIT_FRAC / root); abs <= root, so the
    // first step sees abs itself as its shifted remainder and later steps shift in 0.
    logic              dv_vld_reg  [1:QUOT_W];
    logic [W-1:0]      dv_den_reg  [1:QUOT_W];
    logic [2:0]        dv_neg_reg  [1:QUOT_W];
    logic [W-1:0]      dv_rem_reg  [1:QUOT_W][0:2];
    logic [QUOT_W-1:0] dv_quot_reg [1:QUOT_W][0:2];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        logic              vld_in;
        logic [W-1:0]      den_in;
        logic [2:0]        neg_in;
        logic [QUOT_W-1:0] quot_in [0:2];
        logic [W:0]        rem_sh  [0:2];
        logic [W:0]        diff    [0:2];
        logic [2:0]        fits;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                vld_in = rt_vld_reg[W];
                den_in = rt_root_reg[W];
                neg_in = rt_neg_reg[W];
                for (int i = 0; i < 3; i++)
                begin
                    rem_sh[i]  = {1'b0, rt_abs_reg[W][i]};
                    quot_in[i] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vld_in = dv_vld_reg[j];
                den_in = dv_den_reg[j];
                neg_in = dv_neg_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    rem_sh[i]  = {dv_rem_reg[j][i], 1'b0};
                    quot_in[i] = dv_quot_reg[j][i];
                end
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff[i] = rem_sh[i] - {1'b0, den_in};
                fits[i] = rem_sh[i] >= {1'b0, den_in};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else
                dv_vld_reg[j+1] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            dv_den_reg[j+1] <= den_in;
            dv_neg_reg[j+1] <= neg_in;
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[j+1][i]  <= fits[i] ? diff[i][W-1:0] : rem_sh[i][W-1:0];
                dv_quot_reg[j+1][i] <= {quot_in[i][QUOT_W-2:0], fits[i]};
            end
        end
    end

    // ---------------- output register ----------------
    logic              out_vld_reg;
    logic [W-1:0]      out_mag_reg;
    logic [UNIT_W-1:0] out_unit_reg [0:2];
    logic              out_zero_reg;
    logic              zero_next;
    logic [UNIT_W-1:0] unit_next [0:2];

    assign zero_next = (dv_den_reg[QUOT_W] == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unit_next[i] = UNIT_W'(dv_quot_reg[QUOT_W][i]);
            if (dv_neg_reg[QUOT_W][i])
                unit_next[i] = ~unit_next[i] + 1'b1;
            // Divider output is meaningless for a zero length; force zero
            if (zero_next)
                unit_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= dv_vld_reg[QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        out_mag_reg  <= dv_den_reg[QUOT_W];
        out_zero_reg <= zero_next;
        for (int i = 0; i < 3; i++)
        begin
            out_unit_reg[i] <= unit_next[i];
        end
    end

    assign done        = out_vld_reg;
    assign magnitude   = out_mag_reg;
    assign unit_x      = out_unit_reg[0];
    assign unit_y      = out_unit_reg[1];
    assign unit_z      = out_unit_reg[2];
    assign zero_length = out_zero_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result word without matching command");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (zero_length == (magnitude == '0)))
        else $error("zero flag disagrees with length");

    a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_length) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("unit vector not cleared for zero length");

    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(unit_x) <= $signed(UNIT_W'(1) << UNIT_FRAC) &&
                  $signed(unit_x) >= -$signed(UNIT_W'(1) << UNIT_FRAC) &&
                  INT_BITS >= 0))
        else $error("unit component out of range");

endmodule

### verif/v3n_checker.sv
`timescale 1ns / 100ps

module v3n_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [31:0]                   vec_x,
    input  logic signed [31:0]                   vec_y,
    input  logic signed [31:0]                   vec_z,
    input  logic                                 done,
    input  logic        [31:0]                   magnitude,
    input  logic signed [v3n_pkg::UNIT_W-1:0]    unit_x,
    input  logic signed [v3n_pkg::UNIT_W-1:0]    unit_y,
    input  logic signed [v3n_pkg::UNIT_W-1:0]    unit_z,
    input  logic                                 zero_length,
    output int                                   errors,
    output int                                   pending
);

    typedef struct packed {
        logic        [31:0]                mag;
        logic signed [v3n_pkg::UNIT_W-1:0] ux;
        logic signed [v3n_pkg::UNIT_W-1:0] uy;
        logic signed [v3n_pkg::UNIT_W-1:0] uz;
        logic                              zero;
    } norm_t;

    norm_t expected_norms[$];

    // floor of the square root of a sum of three squares (below 2^64)
    function automatic logic [31:0] floor_root(logic [65:0] n);
        logic [65:0] root;
        logic [67:0] rem;
        logic [67:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | ((n >> (2 * i)) & 66'd3);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 66'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[31:0];
    endfunction

    // one unit component: |c| * 2^30 / length, truncated toward zero
    function automatic logic [31:0] unit_part(logic [31:0] absc, logic neg, logic [31:0] len);
        logic [63:0] q;
        q = ({32'd0, absc} << v3n_pkg::UNIT_FRAC) / {32'd0, len};
        if (neg)
            q = -q;
        return q[31:0];
    endfunction

    function automatic norm_t predict_normal(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [31:0] ax, ay, az;
        logic [65:0] sum;
        norm_t r;
        ax  = x[31] ? -x : x;
        ay  = y[31] ? -y : y;
        az  = z[31] ? -z : z;
        sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
        r.mag = floor_root(sum);
        if (r.mag == 0) begin
            r.ux   = '0;
            r.uy   = '0;
            r.uz   = '0;
            r.zero = 1'b1;
        end else begin
            r.ux   = unit_part(ax, x[31], r.mag);
            r.uy   = unit_part(ay, y[31], r.mag);
            r.uz   = unit_part(az, z[31], r.mag);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk) begin
        norm_t want;
        if (rst_n) begin
            if (start && !busy)
                expected_norms.push_back(predict_normal(vec_x, vec_y, vec_z));
            if (done) begin
                if (expected_norms.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, magnitude %h", $time, magnitude);
                end else begin
                    want = expected_norms.pop_front();
                    if (magnitude !== want.mag) begin
                        errors++;
                        $display("%0t: magnitude expected %h actual %h",
                                 $time, want.mag, magnitude);
                    end
                    if (unit_x !== want.ux) begin
                        errors++;
                        $display("%0t: unit_x expected %h actual %h", $time, want.ux, unit_x);
                    end
                    if (unit_y !== want.uy) begin
                        errors++;
                        $display("%0t: unit_y expected %h actual %h", $time, want.uy, unit_y);
                    end
                    if (unit_z !== want.uz) begin
                        errors++;
                        $display("%0t: unit_z expected %h actual %h", $time, want.uz, unit_z);
                    end
                    if (zero_length !== want.zero) begin
                        errors++;
                        $display("%0t: zero_length expected %b actual %b",
                                 $time, want.zero, zero_length);
                    end
                end
            end
            pending <= expected_norms.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY     = 32 + 35;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_WORDS = 500;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic        done;
    logic [31:0] magnitude;
    logic signed [v3n_pkg::UNIT_W-1:0] unit_x, unit_y, unit_z;
    logic        zero_length;
    int          errors;
    int          pending;
    int          cycles;
    int          idle_pct;

    vector3_normalize dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .done(done), .magnitude(magnitude),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .zero_length(zero_length)
    );

    v3n_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .done(done), .magnitude(magnitude),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .zero_length(zero_length),
        .errors(errors), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if the pipeline stops draining.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one word; hold it until the block takes it. Idle cycles
    // go first so gaps land at random points of the pipeline fill.
    task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Pick one component: full random in four of ten picks, with small values,
    // extremes and zeros mixed in to hit short vectors and axis cases.
    function automatic logic [31:0] pick_component();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3, 4:    return 32'($signed($urandom_range(512)) - 256);
            5:       return 32'($signed($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Hold the sender until every outstanding word has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 87, 0, 17};
        rst_n    = 1'b0;
        start    = 1'b0;
        vec_x    = '0;
        vec_y    = '0;
        vec_z    = '0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: zero vector, extremes, axes and tiny vectors.
        send_word(32'd0, 32'd0, 32'd0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_word(32'h8000_0000, 32'd0, 32'd0);
        send_word(32'd0, 32'h8000_0000, 32'd0);
        send_word(32'd0, 32'd0, 32'h8000_0000);
        send_word(32'h7fff_ffff, 32'd0, 32'd0);
        send_word(32'd1, 32'd0, 32'd0);
        send_word(32'hffff_ffff, 32'd0, 32'd0);
        send_word(32'd0, 32'hffff_ffff, 32'd1);
        send_word(32'd1, 32'd1, 32'd1);
        send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_word(32'h0003_0000, 32'hfffc_0000, 32'd0);
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(32'h0000_ffff, 32'hffff_0001, 32'h5555_5555);
        send_word(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        drain();

        // Random phases with sender idle rates of 0, 87, 0 and 17 percent; drain between.
        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            repeat (PHASE_WORDS)
                send_word(pick_component(), pick_component(), pick_component());
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### vector3_normalize.f
rtl/v3n_pkg.sv
rtl/vector3_normalize.sv
verif/v3n_checker.sv
verif/tb_top.sv
